>>> src/tree_plru_replacement_top_defines.svh
// assertion macros for the tree pseudo-lru replacement block
`ifndef TREE_PLRU_REPLACEMENT_TOP_DEFINES_SVH
`define TREE_PLRU_REPLACEMENT_TOP_DEFINES_SVH

// same-cycle implication, checked on aclk outside reset
`define TPLRU_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on aclk outside reset
`define TPLRU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/tplru_pkg.sv
// shared types and constants of the tree pseudo-lru replacement block
package tplru_pkg;

    localparam int SET_W       = 11;
    localparam int WAY_W       = 4;
    localparam int VICTIM_W    = 4;
    localparam int MODE_W      = 2;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 8;

    localparam int SET_LSB  = 0;
    localparam int WAY_LSB  = 11;
    localparam int HIT_BIT  = 15;
    localparam int WR_BIT   = 16;

    typedef enum logic [MODE_W-1:0] {
        MODE_QUERY  = 2'd0,
        MODE_FILL   = 2'd1,
        MODE_ACCESS = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        KIND_QUERY,
        KIND_ZERO,
        KIND_TOUCH
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic [SET_W-1:0]   set_idx;
        logic [WAY_W-1:0]   way;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

>>> src/tree_plru_replacement_top.sv
// Tree pseudo-LRU replacement store for a set-associative cache, WAYS-1 tree bits per set.
// Words on the slave side carry a mode in s_tuser (victim query, fill, access report);
// a victim query returns one word with the chosen way, other modes return nothing.
// After reset a clearing sweep writes zeros to every set of the tree store, one set per
// cycle, and s_tready stays low meanwhile. Words that update nothing are taken and
// dropped in the front end. In the back end a query or update first reads the set's
// tree bits from the single-port-read store, then walks the tree and either writes the
// bits back or registers the victim (a query for a set out of range returns way 0); a
// two-word queue between front and back lets input and output stall independently.
`include "tree_plru_replacement_top_defines.svh"

module tree_plru_replacement_top import tplru_pkg::*; #(
    parameter int WAYS = 16,
    parameter int SETS = 2048
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // set_index[10:0], way_index[14:11], was_hit[15], is_write[16], zero pad
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // mode[1:0]
    input  logic [MODE_W-1:0]      s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // victim_way[3:0], zero pad
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    job_t    q_job;
    logic    q_valid;
    logic    q_pop;
    q_stat_t q_stat;
    logic    clearing;

    tplru_front #(
        .WAYS (WAYS),
        .SETS (SETS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .clearing (clearing),
        .q_job    (q_job),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_stat   (q_stat)
    );

    tplru_back #(
        .WAYS (WAYS),
        .SETS (SETS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_job    (q_job),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .clearing (clearing),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    `TPLRU_ASSERT_NOW(a_no_take_in_clear, clearing, !s_tready, "word taken during clearing sweep")
    `TPLRU_ASSERT_NOW(a_no_take_when_full, q_stat.full, !s_tready, "word taken with queue full")
    `TPLRU_ASSERT_NOW(a_idle_after_clear, $fell(clearing), q_stat.empty && !m_tvalid,
        "work present at end of clearing sweep")

endmodule

>>> src/tplru_ram.sv
// generic single-write, single-read ram with registered read data
module tplru_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> src/tplru_front.sv
// front end: accepts words, classifies them and queues the work for the back end
module tplru_front import tplru_pkg::*; #(
    parameter int WAYS = 16,
    parameter int SETS = 2048
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_TDATA_W-1:0] s_tdata,
    input  logic [MODE_W-1:0]     s_tuser,
    input  logic                  clearing,
    output job_t                  q_job,
    output logic                  q_valid,
    input  logic                  q_pop,
    output q_stat_t               q_stat
);

    logic [SET_W-1:0] in_set;
    logic [WAY_W-1:0] in_way;
    logic             set_ok;
    logic             way_ok;
    logic             keep;
    logic             push;
    job_t             in_job;

    job_t       ent_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;

    assign in_set = s_tdata[SET_LSB +: SET_W];
    assign in_way = s_tdata[WAY_LSB +: WAY_W];
    assign set_ok = 32'(in_set) < 32'(SETS);
    assign way_ok = 32'(in_way) < 32'(WAYS);

    always_comb begin
        keep           = 1'b0;
        in_job.kind    = KIND_TOUCH;
        in_job.set_idx = in_set;
        in_job.way     = in_way;
        case (mode_t'(s_tuser))
            MODE_QUERY: begin
                keep        = 1'b1;
                in_job.kind = set_ok ? KIND_QUERY : KIND_ZERO;
            end
            MODE_FILL: begin
                keep = set_ok && way_ok;
            end
            MODE_ACCESS: begin
                keep = set_ok && way_ok && s_tdata[HIT_BIT] && !s_tdata[WR_BIT];
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    assign q_stat.full  = cnt_reg == 2'd2;
    assign q_stat.empty = cnt_reg == 2'd0;
    assign s_tready     = !clearing && !q_stat.full;
    assign push         = s_tvalid && s_tready && keep;
    assign q_valid      = !q_stat.empty;
    assign q_job        = ent_reg[rd_ptr_reg];

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !q_pop) begin
            cnt_next = cnt_reg + 2'd1;
        end else if (q_pop && !push) begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (q_pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            ent_reg[wr_ptr_reg] <= in_job;
        end
    end

endmodule

>>> src/tplru_back.sv
// back end: tree bit store, clearing sweep, victim walk and touch update
module tplru_back import tplru_pkg::*; #(
    parameter int WAYS = 16,
    parameter int SETS = 2048
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  job_t                   q_job,
    input  logic                   q_valid,
    output logic                   q_pop,
    output logic                   clearing,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    localparam int ADDR_W = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int TREE_W = WAYS - 1;
    localparam int NODE_W = $clog2(2 * WAYS);
    localparam int VW     = $clog2(WAYS);
    localparam int LEVELS = $clog2(WAYS + 1) - 1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_FETCH,
        ST_EXEC
    } state_t;

    state_t              state_reg;
    logic [ADDR_W-1:0]   clr_cnt_reg;
    job_t                job_reg;
    logic                m_tvalid_reg;
    logic [VICTIM_W-1:0] m_victim_reg;

    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [TREE_W-1:0]   ram_wdata;
    logic                ram_re;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [TREE_W-1:0]   ram_rdata;
    logic                out_free;
    logic                out_load;

    logic [NODE_W-1:0]   walk_node;
    logic [VW-1:0]       victim;
    logic [NODE_W-1:0]   up_node;
    logic [NODE_W-1:0]   up_parent;
    logic [TREE_W-1:0]   up_mask;
    logic [TREE_W-1:0]   touched;

    tplru_ram #(
        .WIDTH (TREE_W),
        .DEPTH (SETS),
        .AW    (ADDR_W)
    ) u_tree_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // root-to-leaf walk for the victim
    always_comb begin
        walk_node = '0;
        victim    = '0;
        for (int k = 0; k < LEVELS; k++) begin
            if (|(TREE_W'(ram_rdata >> walk_node) & TREE_W'(1))) begin
                walk_node = (walk_node << 1) + NODE_W'(2);
                victim    = victim + VW'(WAYS >> (k + 1));
            end else begin
                walk_node = (walk_node << 1) + NODE_W'(1);
            end
        end
    end

    // leaf-to-root walk pointing each parent away from the path
    always_comb begin
        touched   = ram_rdata;
        up_node   = NODE_W'(job_reg.way) + NODE_W'(WAYS - 1);
        up_parent = '0;
        up_mask   = '0;
        for (int k = 0; k < NODE_W; k++) begin
            if (up_node != '0) begin
                up_parent = (up_node - NODE_W'(1)) >> 1;
                up_mask   = TREE_W'(1) << up_parent;
                if (up_node[0]) begin
                    touched = touched | up_mask;
                end else begin
                    touched = touched & ~up_mask;
                end
                up_node = up_parent;
            end
        end
    end

    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = clr_cnt_reg;
        ram_wdata = '0;
        ram_re    = 1'b0;
        ram_raddr = ADDR_W'(q_job.set_idx);
        q_pop     = 1'b0;
        out_load  = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                ram_we = 1'b1;
            end
            ST_FETCH: begin
                if (q_valid) begin
                    if (q_job.kind == KIND_ZERO) begin
                        q_pop    = out_free;
                        out_load = out_free;
                    end else begin
                        q_pop  = 1'b1;
                        ram_re = 1'b1;
                    end
                end
            end
            ST_EXEC: begin
                if (job_reg.kind == KIND_TOUCH) begin
                    ram_we    = 1'b1;
                    ram_waddr = ADDR_W'(job_reg.set_idx);
                    ram_wdata = touched;
                end else begin
                    out_load = out_free;
                end
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_cnt_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_CLEAR: begin
                    clr_cnt_reg <= clr_cnt_reg + ADDR_W'(1);
                    if (clr_cnt_reg == ADDR_W'(SETS - 1)) begin
                        state_reg <= ST_FETCH;
                    end
                end
                ST_FETCH: begin
                    if (q_pop) begin
                        if (q_job.kind == KIND_ZERO) begin
                            m_victim_reg <= '0;
                        end else begin
                            job_reg   <= q_job;
                            state_reg <= ST_EXEC;
                        end
                    end
                end
                ST_EXEC: begin
                    if (job_reg.kind == KIND_TOUCH) begin
                        state_reg <= ST_FETCH;
                    end else if (out_free) begin
                        m_victim_reg <= VICTIM_W'(victim);
                        state_reg    <= ST_FETCH;
                    end
                end
                default: begin
                    state_reg <= ST_FETCH;
                end
            endcase
        end
    end

    assign clearing = state_reg == ST_CLEAR;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = OUT_TDATA_W'(m_victim_reg);

endmodule

>>> tb/tb_top.sv
// testbench for the tree pseudo-lru replacement block: directed and random traffic
`timescale 1ns / 1ps

module tb_top;
    import tplru_pkg::*;

    localparam int NUM_WAYS       = 16;
    localparam int NUM_SETS       = 2048;
    localparam int TREE_W         = NUM_WAYS - 1;
    localparam int WATCHDOG_LIMIT = 12000;
    localparam int TAIL_CYCLES    = 16;
    localparam int POOL_SIZE      = 8;
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

    logic                   aclk;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;
    logic [MODE_W-1:0]      s_tuser  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    logic [TREE_W-1:0]   plru_state [NUM_SETS];
    logic [WAY_W-1:0]    expected_victims [$];
    logic [SET_W-1:0]    hot_sets [POOL_SIZE];
    int                  send_idle_pct  = 0;
    int                  recv_stall_pct = 0;
    int                  error_count    = 0;
    int                  quiet_cycles   = 0;

    tree_plru_replacement_top #(
        .WAYS (NUM_WAYS),
        .SETS (NUM_SETS)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic logic [WAY_W-1:0] victim_of(input logic [TREE_W-1:0] bits);
        int               node;
        int               span;
        logic [WAY_W-1:0] way;
        node = 0;
        span = NUM_WAYS;
        way  = '0;
        while (span > 1) begin
            span = span / 2;
            if (bits[node]) begin
                node = 2 * node + 2;
                way  = way + WAY_W'(span);
            end else begin
                node = 2 * node + 1;
            end
        end
        return way;
    endfunction

    // point every node on the path away from the touched leaf
    function automatic logic [TREE_W-1:0] touched(input logic [TREE_W-1:0] bits,
                                                  input logic [WAY_W-1:0] way);
        int                node;
        int                parent;
        logic [TREE_W-1:0] b;
        b    = bits;
        node = int'(way) + NUM_WAYS - 1;
        while (node > 0) begin
            parent    = (node - 1) / 2;
            b[parent] = (node == 2 * parent + 1);
            node      = parent;
        end
        return b;
    endfunction

    task automatic report_mismatch(input string what);
        $display("ERROR at %0t: %s", $realtime, what);
        error_count++;
    endtask

    task automatic send_word(input logic [MODE_W-1:0] mode, input logic [SET_W-1:0] set_idx,
                             input logic [WAY_W-1:0] way, input logic hit, input logic wr);
        logic [IN_TDATA_W-1:0] data;
        data = '0;
        data[SET_LSB +: SET_W] = set_idx;
        data[WAY_LSB +: WAY_W] = way;
        data[HIT_BIT]          = hit;
        data[WR_BIT]           = wr;
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= mode;
        do @(posedge aclk); while (!s_tready);
        if (set_idx < NUM_SETS) begin
            case (mode)
                MODE_QUERY:  expected_victims.push_back(victim_of(plru_state[set_idx]));
                MODE_FILL:   plru_state[set_idx] = touched(plru_state[set_idx], way);
                MODE_ACCESS: begin
                    if (hit && !wr) plru_state[set_idx] = touched(plru_state[set_idx], way);
                end
                default: ;
            endcase
        end else if (mode == MODE_QUERY) begin
            expected_victims.push_back('0);
        end
    endtask

    // result checker
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_victims.size() == 0) begin
                report_mismatch($sformatf("unexpected result word, victim %0d", m_tdata[3:0]));
            end else if (m_tdata[VICTIM_W-1:0] !== expected_victims[0]) begin
                report_mismatch($sformatf("victim_way got %0d want %0d",
                                          m_tdata[VICTIM_W-1:0], expected_victims[0]));
                void'(expected_victims.pop_front());
            end else begin
                void'(expected_victims.pop_front());
            end
        end
    end

    always @(posedge aclk) begin
        m_tready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL tree_plru_replacement_top");
            $finish;
        end
    end

    task automatic test_cleared_store();
        send_word(MODE_QUERY, '0, 4'd0, 1'b0, 1'b0);
        send_word(MODE_QUERY, SET_W'(NUM_SETS - 1), 4'd15, 1'b1, 1'b1);
        send_word(MODE_QUERY, SET_W'($urandom_range(NUM_SETS - 1)), 4'd7, 1'b1, 1'b0);
    endtask

    task automatic test_touch_paths();
        send_word(MODE_FILL, SET_W'(NUM_SETS - 1), 4'd0, 1'b0, 1'b0);
        send_word(MODE_QUERY, SET_W'(NUM_SETS - 1), 4'd0, 1'b0, 1'b0);
        send_word(MODE_FILL, SET_W'(NUM_SETS - 1), 4'd15, 1'b1, 1'b1);
        send_word(MODE_QUERY, SET_W'(NUM_SETS - 1), 4'd0, 1'b0, 1'b0);
        send_word(MODE_FILL, 11'd1, 4'd7, 1'b0, 1'b1);
        send_word(MODE_QUERY, 11'd1, 4'd0, 1'b0, 1'b0);
    endtask

    // only a read hit moves the tree
    task automatic test_access_filtering();
        send_word(MODE_ACCESS, 11'd3, 4'd5, 1'b1, 1'b0);
        send_word(MODE_QUERY, 11'd3, 4'd0, 1'b0, 1'b0);
        send_word(MODE_ACCESS, 11'd3, 4'd9, 1'b1, 1'b1);
        send_word(MODE_QUERY, 11'd3, 4'd0, 1'b0, 1'b0);
        send_word(MODE_ACCESS, 11'd3, 4'd9, 1'b0, 1'b0);
        send_word(MODE_QUERY, 11'd3, 4'd0, 1'b0, 1'b0);
    endtask

    task automatic test_spare_mode();
        send_word(MODE_SPARE, 11'd3, 4'd0, 1'b1, 1'b0);
        send_word(MODE_QUERY, 11'd3, 4'd0, 1'b0, 1'b0);
    endtask

    task automatic test_random_traffic(input int n_words, input int idle_pct,
                                       input int stall_pct);
        int               sent;
        int               pick;
        logic [SET_W-1:0] set_idx;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        hot_sets[0] = '0;
        hot_sets[1] = SET_W'(NUM_SETS - 1);
        for (int i = 2; i < POOL_SIZE; i++) hot_sets[i] = SET_W'($urandom_range(NUM_SETS - 1));
        sent = 0;
        while (sent < n_words) begin
            if ($urandom_range(99) < 75) set_idx = hot_sets[$urandom_range(POOL_SIZE - 1)];
            else set_idx = SET_W'($urandom_range(NUM_SETS - 1));
            pick = $urandom_range(99);
            if (pick < 25) begin
                // miss handling: ask for a victim, then fill that way
                send_word(MODE_QUERY, set_idx, WAY_W'($urandom), 1'($urandom), 1'($urandom));
                send_word(MODE_FILL, set_idx, victim_of(plru_state[set_idx]),
                          1'($urandom), 1'($urandom));
                sent += 2;
            end else if (pick < 40) begin
                send_word(MODE_QUERY, set_idx, WAY_W'($urandom), 1'($urandom), 1'($urandom));
                sent++;
            end else if (pick < 60) begin
                send_word(MODE_FILL, set_idx, WAY_W'($urandom), 1'($urandom), 1'($urandom));
                sent++;
            end else if (pick < 95) begin
                send_word(MODE_ACCESS, set_idx, WAY_W'($urandom), $urandom_range(99) < 70,
                          $urandom_range(99) < 30);
                sent++;
            end else begin
                send_word(MODE_SPARE, set_idx, WAY_W'($urandom), 1'($urandom), 1'($urandom));
                sent++;
            end
        end
    endtask

    initial begin
        foreach (plru_state[i]) plru_state[i] = '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        test_cleared_store();
        test_touch_paths();
        test_access_filtering();
        test_spare_mode();
        test_random_traffic(410, 0, 0);
        test_random_traffic(410, 85, 0);
        test_random_traffic(410, 0, 85);
        test_random_traffic(410, 30, 30);
        s_tvalid <= 1'b0;
        while (expected_victims.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("PASS tree_plru_replacement_top");
        end else begin
            $display("FAIL tree_plru_replacement_top");
        end
        $finish;
    end

endmodule

>>> files.f
+incdir+src
src/tplru_pkg.sv
src/tplru_ram.sv
src/tplru_front.sv
src/tplru_back.sv
src/tree_plru_replacement_top.sv
tb/tb_top.sv
